>>> src/i2cm_pkg.sv
// ============================================================================
// i2cm_pkg: shared types and constants of the I2C EEPROM block master
// Holds the block geometry, command and register codes, the sequencer phases
// and the structs that travel between the modules.
// ============================================================================
package i2cm_pkg;

	localparam int BLOCK_BYTES     = 16;
	localparam int RECOVERY_PULSES = 9;
	localparam int RECOVERY_ROUNDS = 5;
	localparam int RECOVERY_LIMIT  = RECOVERY_ROUNDS * RECOVERY_PULSES;
	localparam int HDR_BYTES       = 3;
	localparam int BITS_PER_BYTE   = 8;

	localparam int IDX_W      = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
	localparam int BYTE_CNT_W = $clog2(HDR_BYTES + BLOCK_BYTES + 1);
	localparam int REC_CNT_W  = $clog2(RECOVERY_LIMIT + 1);

	localparam logic [6:0]  DEVICE_ADDRESS_RST     = 7'd80;
	localparam logic [7:0]  ACK_POLL_LIMIT_RST     = 8'd255;
	localparam logic [15:0] WRITE_SETTLE_TICKS_RST = 16'd800;
	localparam logic [7:0]  READ_BIT               = 8'h01;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_DEVICE_ADDRESS     = 2'd0,
		CFG_ACK_POLL_LIMIT     = 2'd1,
		CFG_WRITE_SETTLE_TICKS = 2'd2
	} cfg_index_t;

	typedef enum logic [4:0] {
		P_IDLE      = 5'd0,
		P_REC_LOW   = 5'd1,
		P_REC_HIGH  = 5'd2,
		P_START     = 5'd3,
		P_TX_LOW    = 5'd4,
		P_TX_HIGH   = 5'd5,
		P_ACK_LOW   = 5'd6,
		P_ACK_POLL  = 5'd7,
		P_RS_LOW    = 5'd8,
		P_RS_CHECK  = 5'd9,
		P_RX_LOW    = 5'd10,
		P_RX_HIGH   = 5'd11,
		P_RXA_LOW   = 5'd12,
		P_RXA_HIGH  = 5'd13,
		P_STOP_LOW  = 5'd14,
		P_STOP_HIGH = 5'd15,
		P_STOP_REL  = 5'd16,
		P_SETTLE    = 5'd17
	} phase_t;

	typedef struct packed {
		logic [6:0]  device_address;
		logic [7:0]  ack_poll_limit;
		logic [15:0] write_settle_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] mem_address;
		logic [3:0]  byte_index;
		logic [7:0]  write_byte;
		logic        sda_in;
		logic        scl_in;
	} item_t;

	typedef struct packed {
		logic       scl_release;
		logic       sda_release;
		logic [7:0] read_data;
		logic       read_valid;
		logic [3:0] read_position;
		logic       done_res;
		logic       nack_error;
		logic       bus_busy_error;
		logic       busy_res;
	} result_t;

endpackage

>>> src/i2cm_cfg_regs.sv
// ============================================================================
// i2cm_cfg_regs: configuration registers
// Holds the device address, ACK poll limit and write settle time, written
// through a valid/ready port that is always ready.
// ============================================================================
module i2cm_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data,
	output i2cm_pkg::cfg_t cfg
);
	import i2cm_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address     <= DEVICE_ADDRESS_RST;
			cfg_q.ack_poll_limit     <= ACK_POLL_LIMIT_RST;
			cfg_q.write_settle_ticks <= WRITE_SETTLE_TICKS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DEVICE_ADDRESS:     cfg_q.device_address <= cfg_data[6:0];
				CFG_ACK_POLL_LIMIT:     cfg_q.ack_poll_limit <= cfg_data[7:0];
				CFG_WRITE_SETTLE_TICKS: cfg_q.write_settle_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

>>> src/i2cm_engine.sv
// ============================================================================
// i2cm_engine: bus sequencer and write buffer
// Advances the I2C phase machine by one half-bit phase per item and computes
// the line controls and status of that item.
// ============================================================================
module i2cm_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  i2cm_pkg::item_t   item,
	input  i2cm_pkg::cfg_t    cfg,
	output i2cm_pkg::result_t res,
	output logic              idle
);
	import i2cm_pkg::*;

	phase_t                phase_q, phase_d;
	logic [3:0]            bit_q, bit_d;
	logic [BYTE_CNT_W-1:0] byte_q, byte_d;
	logic [7:0]            shift_q, shift_d;
	logic [15:0]           addr_q, addr_d;
	logic [15:0]           wait_q, wait_d;
	logic [REC_CNT_W-1:0]  rec_q, rec_d;
	logic                  nack_q, nack_d;
	logic                  is_read_q, is_read_d;
	logic [7:0]            buf_q [BLOCK_BYTES];

	logic                  load_en;
	logic [IDX_W-1:0]      load_idx;
	logic [BYTE_CNT_W-1:0] tx_k, tx_off;
	logic [IDX_W-1:0]      tx_idx;
	logic                  tx_in_buf;
	logic [7:0]            tx_entry, tx_byte, dev_byte;
	logic [BYTE_CNT_W:0]   bc_inc;
	logic                  ackl;

	function automatic phase_t bus_check(input logic sda, input logic scl,
			input logic [REC_CNT_W-1:0] rec);
		phase_t p;
		if (!sda && (rec < REC_CNT_W'(RECOVERY_LIMIT)))
			p = P_REC_LOW;
		else if (!sda || !scl)
			p = P_IDLE;
		else
			p = P_START;
		return p;
	endfunction

	assign load_en  = (item.cmd == CMD_LOAD) && ({4'd0, item.byte_index} < 8'(BLOCK_BYTES));
	assign load_idx = IDX_W'(item.byte_index);
	assign dev_byte = {cfg.device_address, 1'b0};

	// The byte to send is needed at a start phase for the current count and after
	// an ACK for the next one; only one of them is used in a given phase.
	assign tx_k      = (phase_q == P_START) ? byte_q : byte_q + 1'b1;
	assign tx_off    = tx_k - BYTE_CNT_W'(HDR_BYTES);
	assign tx_in_buf = (tx_k >= BYTE_CNT_W'(HDR_BYTES)) &&
	                   (tx_off < BYTE_CNT_W'(BLOCK_BYTES));
	assign tx_idx    = tx_off[IDX_W-1:0];
	assign tx_entry  = (load_en && load_idx == tx_idx) ? item.write_byte : buf_q[tx_idx];

	always_comb begin
		if (tx_k == BYTE_CNT_W'(0))
			tx_byte = dev_byte;
		else if (tx_k == BYTE_CNT_W'(1))
			tx_byte = addr_q[15:8];
		else if (tx_k == BYTE_CNT_W'(2))
			tx_byte = addr_q[7:0];
		else if (is_read_q)
			tx_byte = dev_byte | READ_BIT;
		else if (tx_in_buf)
			tx_byte = tx_entry;
		else
			tx_byte = 8'd0;
	end

	assign bc_inc = {1'b0, byte_q} + 1'b1;
	assign ackl   = !(bc_inc < (BYTE_CNT_W+1)'(BLOCK_BYTES));

	always_comb begin
		phase_d   = phase_q;
		bit_d     = bit_q;
		byte_d    = byte_q;
		shift_d   = shift_q;
		addr_d    = addr_q;
		wait_d    = wait_q;
		rec_d     = rec_q;
		nack_d    = nack_q;
		is_read_d = is_read_q;
		res       = '0;
		res.scl_release = 1'b1;
		res.sda_release = 1'b1;

		case (phase_q)
			P_REC_LOW, P_ACK_LOW, P_RS_LOW, P_RX_LOW: res.scl_release = 1'b0;
			P_START: res.sda_release = 1'b0;
			P_TX_LOW: begin
				res.scl_release = 1'b0;
				res.sda_release = shift_q[7];
			end
			P_TX_HIGH: res.sda_release = shift_q[7];
			P_RXA_LOW: begin
				res.scl_release = 1'b0;
				res.sda_release = ackl;
			end
			P_RXA_HIGH: res.sda_release = ackl;
			P_STOP_LOW: begin
				res.scl_release = 1'b0;
				res.sda_release = 1'b0;
			end
			P_STOP_HIGH: res.sda_release = 1'b0;
			default: ;
		endcase

		case (phase_q)
			P_IDLE: begin
				if (item.cmd == CMD_WRITE || item.cmd == CMD_READ) begin
					addr_d    = item.mem_address;
					is_read_d = (item.cmd == CMD_READ);
					nack_d    = 1'b0;
					rec_d     = '0;
					byte_d    = '0;
					phase_d   = bus_check(item.sda_in, item.scl_in, '0);
					if (phase_d == P_IDLE) begin
						res.done_res       = 1'b1;
						res.bus_busy_error = 1'b1;
					end
				end
			end
			P_REC_LOW: phase_d = P_REC_HIGH;
			P_REC_HIGH: begin
				rec_d   = rec_q + 1'b1;
				phase_d = bus_check(item.sda_in, item.scl_in, rec_d);
				if (phase_d == P_IDLE) begin
					res.done_res       = 1'b1;
					res.bus_busy_error = 1'b1;
				end
			end
			P_START: begin
				shift_d = tx_byte;
				bit_d   = '0;
				phase_d = P_TX_LOW;
			end
			P_TX_LOW: phase_d = P_TX_HIGH;
			P_TX_HIGH: begin
				shift_d = {shift_q[6:0], 1'b0};
				bit_d   = bit_q + 1'b1;
				phase_d = (bit_d >= 4'(BITS_PER_BYTE)) ? P_ACK_LOW : P_TX_LOW;
			end
			P_ACK_LOW: begin
				wait_d  = '0;
				phase_d = P_ACK_POLL;
			end
			P_ACK_POLL: begin
				if (!item.sda_in) begin
					if (!is_read_q) begin
						byte_d = byte_q + 1'b1;
						if (byte_d < BYTE_CNT_W'(HDR_BYTES + BLOCK_BYTES)) begin
							shift_d = tx_byte;
							bit_d   = '0;
							phase_d = P_TX_LOW;
						end else begin
							phase_d = P_STOP_LOW;
						end
					end else if (byte_q < BYTE_CNT_W'(HDR_BYTES - 1)) begin
						byte_d  = byte_q + 1'b1;
						shift_d = tx_byte;
						bit_d   = '0;
						phase_d = P_TX_LOW;
					end else if (byte_q == BYTE_CNT_W'(HDR_BYTES - 1)) begin
						byte_d  = BYTE_CNT_W'(HDR_BYTES);
						phase_d = P_RS_LOW;
					end else begin
						byte_d  = '0;
						bit_d   = '0;
						shift_d = '0;
						phase_d = P_RX_LOW;
					end
				end else begin
					wait_d = wait_q + 1'b1;
					if (wait_d >= {8'd0, cfg.ack_poll_limit}) begin
						nack_d  = 1'b1;
						phase_d = P_STOP_LOW;
					end
				end
			end
			P_RS_LOW: phase_d = P_RS_CHECK;
			P_RS_CHECK: begin
				if (!item.sda_in || !item.scl_in) begin
					phase_d            = P_IDLE;
					res.done_res       = 1'b1;
					res.bus_busy_error = 1'b1;
				end else begin
					phase_d = P_START;
				end
			end
			P_RX_LOW: phase_d = P_RX_HIGH;
			P_RX_HIGH: begin
				shift_d = {shift_q[6:0], item.sda_in};
				bit_d   = bit_q + 1'b1;
				if (bit_d >= 4'(BITS_PER_BYTE)) begin
					res.read_valid    = 1'b1;
					res.read_data     = shift_d;
					res.read_position = byte_q[3:0];
					phase_d           = P_RXA_LOW;
				end else begin
					phase_d = P_RX_LOW;
				end
			end
			P_RXA_LOW: phase_d = P_RXA_HIGH;
			P_RXA_HIGH: begin
				byte_d  = byte_q + 1'b1;
				bit_d   = '0;
				shift_d = '0;
				phase_d = (byte_d >= BYTE_CNT_W'(BLOCK_BYTES)) ? P_STOP_LOW : P_RX_LOW;
			end
			P_STOP_LOW: phase_d = P_STOP_HIGH;
			P_STOP_HIGH: phase_d = P_STOP_REL;
			P_STOP_REL: begin
				if (!is_read_q && cfg.write_settle_ticks != 16'd0) begin
					wait_d  = '0;
					phase_d = P_SETTLE;
				end else begin
					phase_d        = P_IDLE;
					res.done_res   = 1'b1;
					res.nack_error = nack_q;
				end
			end
			P_SETTLE: begin
				wait_d = wait_q + 1'b1;
				if (wait_d >= cfg.write_settle_ticks) begin
					phase_d        = P_IDLE;
					res.done_res   = 1'b1;
					res.nack_error = nack_q;
				end
			end
			default: phase_d = P_IDLE;
		endcase

		res.busy_res = (phase_d != P_IDLE);
	end

	assign idle = (phase_q == P_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= P_IDLE;
			bit_q     <= '0;
			byte_q    <= '0;
			shift_q   <= '0;
			addr_q    <= '0;
			wait_q    <= '0;
			rec_q     <= '0;
			nack_q    <= 1'b0;
			is_read_q <= 1'b0;
		end else if (advance) begin
			phase_q   <= phase_d;
			bit_q     <= bit_d;
			byte_q    <= byte_d;
			shift_q   <= shift_d;
			addr_q    <= addr_d;
			wait_q    <= wait_d;
			rec_q     <= rec_d;
			nack_q    <= nack_d;
			is_read_q <= is_read_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load_en)
			buf_q[load_idx] <= item.write_byte;
	end

`ifndef SYNTHESIS
	a_bits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= 4'(BITS_PER_BYTE))
		else $error("bit counter ran past one byte");

	a_rec_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		rec_q <= REC_CNT_W'(RECOVERY_LIMIT))
		else $error("recovery pulse count ran past its limit");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.done_res) |=> (phase_q == P_IDLE))
		else $error("transaction ended but sequencer is not idle");
`endif

endmodule

>>> src/i2c_eeprom_block_master.sv
// ============================================================================
// i2c_eeprom_block_master: I2C master for a 16-bit-addressed EEPROM
// Input item register, bus sequencer and result register with handshakes.
// ============================================================================
// Each input item is one half-bit bus phase (or a buffer load) and yields
// exactly one result item. The block takes one item per clock cycle while the
// result side does not stall, and each result passes through the input
// register, then the result register. The phase state register of the
// sequencer is updated once per accepted item.
// A held result blocks only when both registers are full.
module i2c_eeprom_block_master (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [15:0] mem_address,
	input  logic [3:0]  byte_index,
	input  logic [7:0]  write_byte,
	input  logic        sda_in,
	input  logic        scl_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        scl_release,
	output logic        sda_release,
	output logic [7:0]  read_data,
	output logic        read_valid,
	output logic [3:0]  read_position,
	output logic        done_res,
	output logic        nack_error,
	output logic        bus_busy_error,
	output logic        busy_res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import i2cm_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_c, res_s2;
	logic    valid_s2;
	logic    adv;
	logic    seq_idle;

	i2cm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.cmd         <= cmd;
			item_s1.mem_address <= mem_address;
			item_s1.byte_index  <= byte_index;
			item_s1.write_byte  <= write_byte;
			item_s1.sda_in      <= sda_in;
			item_s1.scl_in      <= scl_in;
		end
	end

	i2cm_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (adv),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res_c),
		.idle    (seq_idle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res_c;
	end

	assign out_valid      = valid_s2;
	assign scl_release    = res_s2.scl_release;
	assign sda_release    = res_s2.sda_release;
	assign read_data      = res_s2.read_data;
	assign read_valid     = res_s2.read_valid;
	assign read_position  = res_s2.read_position;
	assign done_res       = res_s2.done_res;
	assign nack_error     = res_s2.nack_error;
	assign bus_busy_error = res_s2.bus_busy_error;
	assign busy_res       = res_s2.busy_res;

`ifndef SYNTHESIS
	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("processed item did not reach the result register");

	a_error_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (nack_error || bus_busy_error)) |-> done_res)
		else $error("error flag shown outside the end of a transaction");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && done_res) |-> !busy_res)
		else $error("transaction ended but still reported busy");

	a_busy_tracks_seq: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (res_s2.busy_res == !seq_idle))
		else $error("busy status disagrees with sequencer phase");
`endif

endmodule

>>> tb/i2c_eeprom_block_master_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// i2c_eeprom_block_master_tb: self-checking bench for the I2C block master
// Drives tick, load and start items through the input handshake and acts as
// the bus. The line levels follow the master, and a slave acknowledges, sends
// data, stretches, sticks the bus or withholds its ACK. A cycle-true
// sequencer predictor gives the expected result of each untyped item. The
// run goes through several register settings, including the extremes.
// ============================================================================
module i2c_eeprom_block_master_tb;
	import i2cm_pkg::*;

	localparam int PHASE_ITEMS = 215;
	localparam int CFG_SETS    = 4;
	localparam int HOLD_FROM   = 300;
	localparam int HOLD_LEN    = 250;
	localparam int CALM_FROM   = 1500;
	localparam int CALM_TO     = 2500;
	localparam logic [1:0] CFG_SPARE = 2'd3;

	localparam result_t IDLE_RES     = {1'b1, 1'b1, 8'h00, 1'b0, 4'h0, 1'b0, 1'b0, 1'b0, 1'b0};
	localparam result_t BUS_BUSY_RES = {1'b1, 1'b1, 8'h00, 1'b0, 4'h0, 1'b1, 1'b0, 1'b1, 1'b0};

	typedef struct {
		item_t   it;
		bit      typed;
		result_t want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd = CMD_TICK;
	logic [15:0] mem_address = '0;
	logic [3:0]  byte_index = '0;
	logic [7:0]  write_byte = '0;
	logic        sda_in = 1'b1;
	logic        scl_in = 1'b1;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        scl_release;
	logic        sda_release;
	logic [7:0]  read_data;
	logic        read_valid;
	logic [3:0]  read_position;
	logic        done_res;
	logic        nack_error;
	logic        bus_busy_error;
	logic        busy_res;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// Predictor state and its copy of the registers.
	phase_t      ph_q = P_IDLE;
	int          bit_q = 0;
	int          byte_q = 0;
	int          wait_q = 0;
	int          rec_cnt = 0;
	logic [7:0]  sh_q = '0;
	logic [15:0] addr_q = '0;
	logic        nack_q = 1'b0;
	logic        rd_q = 1'b0;
	logic [7:0]  wbuf [BLOCK_BYTES];
	logic [6:0]  cfg_dev = DEVICE_ADDRESS_RST;
	logic [7:0]  cfg_poll = ACK_POLL_LIMIT_RST;
	logic [15:0] cfg_settle = WRITE_SETTLE_TICKS_RST;

	// Behavior of the simulated slave for the transaction in progress.
	int          nack_at = -1;
	int          release_after = 3;
	bit          rs_stuck = 1'b0;
	bit          writes_ok = 1'b0;
	logic [15:0] loaded = '0;

	result_t     due_results [$];
	int          items_sent = 0;
	int          errors = 0;
	int          rx_cycle = 0;
	int          ended = 0;
	int          ended_nack = 0;
	int          ended_busy = 0;
	int          bytes_read = 0;

	i2c_eeprom_block_master DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5000000;
		$display("Mismatches found");
		$finish;
	end

	function automatic void line_levels(output logic scl_o, output logic sda_o);
		scl_o = 1'b1;
		sda_o = 1'b1;
		case (ph_q)
			P_REC_LOW, P_ACK_LOW, P_RS_LOW, P_RX_LOW: scl_o = 1'b0;
			P_START: sda_o = 1'b0;
			P_TX_LOW: begin
				scl_o = 1'b0;
				sda_o = sh_q[7];
			end
			P_TX_HIGH: sda_o = sh_q[7];
			P_RXA_LOW: begin
				scl_o = 1'b0;
				sda_o = (byte_q + 1 >= BLOCK_BYTES);
			end
			P_RXA_HIGH: sda_o = (byte_q + 1 >= BLOCK_BYTES);
			P_STOP_LOW: begin
				scl_o = 1'b0;
				sda_o = 1'b0;
			end
			P_STOP_HIGH: sda_o = 1'b0;
			default: ;
		endcase
	endfunction

	function automatic logic [7:0] tx_byte(int k);
		logic [7:0] dev;
		dev = {cfg_dev, 1'b0};
		if (k == 0) return dev;
		if (k == 1) return addr_q[15:8];
		if (k == 2) return addr_q[7:0];
		if (rd_q) return dev | READ_BIT;
		if (k - HDR_BYTES < BLOCK_BYTES) return wbuf[k - HDR_BYTES];
		return 8'h00;
	endfunction

	function automatic void load_shifter(logic [7:0] v);
		sh_q = v;
		bit_q = 0;
		ph_q = P_TX_LOW;
	endfunction

	// Lines were released on this tick; returns 1 when the bus is busy.
	function automatic bit bus_check(logic sda, logic scl);
		if (!sda && rec_cnt < RECOVERY_LIMIT) begin
			ph_q = P_REC_LOW;
			return 1'b0;
		end
		if (!sda || !scl) begin
			ph_q = P_IDLE;
			return 1'b1;
		end
		ph_q = P_START;
		return 1'b0;
	endfunction

	function automatic result_t sequencer_step(item_t it);
		result_t r;
		logic    scl_o;
		logic    sda_o;
		line_levels(scl_o, sda_o);
		r = '0;
		r.scl_release = scl_o;
		r.sda_release = sda_o;
		if (it.cmd == CMD_LOAD && int'(it.byte_index) < BLOCK_BYTES)
			wbuf[it.byte_index] = it.write_byte;
		case (ph_q)
			P_IDLE: if (it.cmd == CMD_WRITE || it.cmd == CMD_READ) begin
				addr_q = it.mem_address;
				rd_q = (it.cmd == CMD_READ);
				nack_q = 1'b0;
				rec_cnt = 0;
				byte_q = 0;
				if (bus_check(it.sda_in, it.scl_in)) begin
					r.done_res = 1'b1;
					r.bus_busy_error = 1'b1;
				end
			end
			P_REC_LOW: ph_q = P_REC_HIGH;
			P_REC_HIGH: begin
				rec_cnt++;
				if (bus_check(it.sda_in, it.scl_in)) begin
					r.done_res = 1'b1;
					r.bus_busy_error = 1'b1;
				end
			end
			P_START: load_shifter(tx_byte(byte_q));
			P_TX_LOW: ph_q = P_TX_HIGH;
			P_TX_HIGH: begin
				sh_q = sh_q << 1;
				bit_q++;
				ph_q = (bit_q >= BITS_PER_BYTE) ? P_ACK_LOW : P_TX_LOW;
			end
			P_ACK_LOW: begin
				wait_q = 0;
				ph_q = P_ACK_POLL;
			end
			P_ACK_POLL: if (!it.sda_in) begin
				if (!rd_q) begin
					byte_q++;
					if (byte_q < HDR_BYTES + BLOCK_BYTES) load_shifter(tx_byte(byte_q));
					else ph_q = P_STOP_LOW;
				end else if (byte_q < HDR_BYTES - 1) begin
					byte_q++;
					load_shifter(tx_byte(byte_q));
				end else if (byte_q == HDR_BYTES - 1) begin
					byte_q = HDR_BYTES;
					ph_q = P_RS_LOW;
				end else begin
					byte_q = 0;
					bit_q = 0;
					sh_q = '0;
					ph_q = P_RX_LOW;
				end
			end else begin
				wait_q++;
				if (wait_q >= cfg_poll) begin
					nack_q = 1'b1;
					ph_q = P_STOP_LOW;
				end
			end
			P_RS_LOW: ph_q = P_RS_CHECK;
			P_RS_CHECK: if (!it.sda_in || !it.scl_in) begin
				ph_q = P_IDLE;
				r.done_res = 1'b1;
				r.bus_busy_error = 1'b1;
			end else begin
				ph_q = P_START;
			end
			P_RX_LOW: ph_q = P_RX_HIGH;
			P_RX_HIGH: begin
				sh_q = {sh_q[6:0], it.sda_in};
				bit_q++;
				if (bit_q >= BITS_PER_BYTE) begin
					r.read_valid = 1'b1;
					r.read_data = sh_q;
					r.read_position = byte_q[3:0];
					ph_q = P_RXA_LOW;
				end else begin
					ph_q = P_RX_LOW;
				end
			end
			P_RXA_LOW: ph_q = P_RXA_HIGH;
			P_RXA_HIGH: begin
				byte_q++;
				bit_q = 0;
				sh_q = '0;
				ph_q = (byte_q >= BLOCK_BYTES) ? P_STOP_LOW : P_RX_LOW;
			end
			P_STOP_LOW: ph_q = P_STOP_HIGH;
			P_STOP_HIGH: ph_q = P_STOP_REL;
			P_STOP_REL: if (!rd_q && cfg_settle > 0) begin
				wait_q = 0;
				ph_q = P_SETTLE;
			end else begin
				ph_q = P_IDLE;
				r.done_res = 1'b1;
				r.nack_error = nack_q;
			end
			P_SETTLE: begin
				wait_q++;
				if (wait_q >= cfg_settle) begin
					ph_q = P_IDLE;
					r.done_res = 1'b1;
					r.nack_error = nack_q;
				end
			end
			default: ph_q = P_IDLE;
		endcase
		r.busy_res = (ph_q != P_IDLE);
		return r;
	endfunction

	// Picks the next item from the sequencer state, playing the slave side.
	function automatic item_t make_item();
		item_t it;
		logic  scl_o;
		logic  sda_o;
		int    pick;
		int    k;
		it.cmd = CMD_TICK;
		it.mem_address = 16'($urandom);
		it.byte_index = 4'($urandom);
		it.write_byte = 8'($urandom);
		line_levels(scl_o, sda_o);
		it.scl_in = scl_o;
		it.sda_in = sda_o;
		case (ph_q)
			P_IDLE: begin
				it.sda_in = 1'($urandom);
				it.scl_in = 1'($urandom);
				if (loaded != '1) begin
					k = $urandom_range(0, BLOCK_BYTES - 1);
					while (loaded[k]) k = (k + 1) % BLOCK_BYTES;
					it.cmd = CMD_LOAD;
					it.byte_index = k[3:0];
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 25) begin
						it.cmd = CMD_LOAD;
					end else if (pick >= 50) begin
						it.cmd = (writes_ok && $urandom_range(0, 1)) ? CMD_WRITE : CMD_READ;
						it.sda_in = ($urandom_range(0, 99) >= 10);
						it.scl_in = ($urandom_range(0, 99) >= 5);
						nack_at = ($urandom_range(0, 99) < 20) ?
							$urandom_range(0, HDR_BYTES + BLOCK_BYTES - 1) : -1;
						release_after = $urandom_range(0, RECOVERY_LIMIT + 5);
						rs_stuck = ($urandom_range(0, 99) < 8);
					end
				end
			end
			P_REC_HIGH: it.sda_in = (rec_cnt >= release_after);
			P_ACK_POLL: it.sda_in = !(byte_q != nack_at &&
				(cfg_poll <= 3 || $urandom_range(0, 99) < 75));
			P_RS_CHECK: it.sda_in = !rs_stuck;
			P_RX_HIGH: it.sda_in = 1'($urandom);
			default: ;
		endcase
		if (ph_q != P_IDLE) begin
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				it.cmd = CMD_LOAD;
			end else if (pick < 6) begin
				it.cmd = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
			end else if (pick < 10) begin
				it.sda_in = 1'($urandom);
				it.scl_in = 1'($urandom);
			end
		end
		if (it.cmd == CMD_LOAD) loaded[it.byte_index] = 1'b1;
		return it;
	endfunction

	function automatic stim_row_t mk_row(cmd_t c, logic [15:0] a, logic [3:0] i,
			logic [7:0] d, logic sda, logic scl, bit typed, result_t want);
		stim_row_t r;
		r.it = {c, a, i, d, sda, scl};
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	task automatic send_item(item_t it, bit typed, result_t want);
		result_t r;
		if (!(items_sent >= 700 && items_sent < 900) && $urandom_range(0, 99) < 11) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= it.cmd;
		mem_address <= it.mem_address;
		byte_index <= it.byte_index;
		write_byte <= it.write_byte;
		sda_in <= it.sda_in;
		scl_in <= it.scl_in;
		do @(posedge clk); while (!in_ready);
		r = sequencer_step(it);
		due_results.push_back(typed ? want : r);
		items_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_DEVICE_ADDRESS: cfg_dev = val[6:0];
			CFG_ACK_POLL_LIMIT: cfg_poll = val[7:0];
			CFG_WRITE_SETTLE_TICKS: cfg_settle = val;
			default: ;
		endcase
	endtask

	initial begin : stimulus
		stim_row_t rows [11];
		int        n;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows[0]  = mk_row(CMD_TICK,  16'h0000, 4'd0,  8'h00, 1'b1, 1'b1, 1'b1, IDLE_RES);
		rows[1]  = mk_row(CMD_TICK,  16'hFFFF, 4'd15, 8'hFF, 1'b0, 1'b0, 1'b1, IDLE_RES);
		rows[2]  = mk_row(CMD_LOAD,  16'h0000, 4'd0,  8'h00, 1'b1, 1'b1, 1'b1, IDLE_RES);
		rows[3]  = mk_row(CMD_LOAD,  16'hFFFF, 4'd15, 8'hFF, 1'b1, 1'b1, 1'b1, IDLE_RES);
		rows[4]  = mk_row(CMD_WRITE, 16'hFFFF, 4'd0,  8'h00, 1'b1, 1'b0, 1'b1, BUS_BUSY_RES);
		rows[5]  = mk_row(CMD_READ,  16'h0000, 4'd0,  8'h00, 1'b0, 1'b1, 1'b0, '0);
		rows[6]  = mk_row(CMD_TICK,  16'h1234, 4'd3,  8'h5A, 1'b0, 1'b0, 1'b0, '0);
		rows[7]  = mk_row(CMD_TICK,  16'h0000, 4'd0,  8'h00, 1'b0, 1'b1, 1'b0, '0);
		rows[8]  = mk_row(CMD_TICK,  16'h0000, 4'd0,  8'h00, 1'b0, 1'b0, 1'b0, '0);
		rows[9]  = mk_row(CMD_TICK,  16'h0000, 4'd0,  8'h00, 1'b1, 1'b1, 1'b0, '0);
		rows[10] = mk_row(CMD_WRITE, 16'hA5C3, 4'd7,  8'h81, 1'b0, 1'b1, 1'b0, '0);
		loaded[0] = 1'b1;
		loaded[BLOCK_BYTES - 1] = 1'b1;
		foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].want);

		for (int s = 0; s < CFG_SETS; s++) begin
			if (s > 0) begin
				drain_results();
				case (s)
					1: begin
						write_reg(CFG_DEVICE_ADDRESS, 16'hFFFF);
						write_reg(CFG_ACK_POLL_LIMIT, 16'd1);
						write_reg(CFG_WRITE_SETTLE_TICKS, 16'd0);
						writes_ok = 1'b1;
					end
					2: begin
						write_reg(CFG_DEVICE_ADDRESS, 16'h0000);
						write_reg(CFG_ACK_POLL_LIMIT, 16'd0);
						write_reg(CFG_WRITE_SETTLE_TICKS, 16'd2);
						write_reg(CFG_SPARE, 16'hFFFF);
					end
					3: begin
						write_reg(CFG_DEVICE_ADDRESS, 16'h002A);
						write_reg(CFG_ACK_POLL_LIMIT, 16'd255);
						write_reg(CFG_WRITE_SETTLE_TICKS, 16'hFFFF);
						writes_ok = 1'b0;
					end
					default: begin
						write_reg(CFG_DEVICE_ADDRESS, 16'($urandom));
						write_reg(CFG_ACK_POLL_LIMIT, 16'd3);
						write_reg(CFG_WRITE_SETTLE_TICKS, 16'd1);
					end
				endcase
				cfg_valid <= 1'b0;
			end
			n = 0;
			while (n < PHASE_ITEMS || ph_q != P_IDLE) begin
				send_item(make_item(), 1'b0, '0);
				n++;
			end
		end
		drain_results();

		$display("Covered %0d items under %0d register settings; %0d transactions ended.",
			items_sent, CFG_SETS, ended);
		$display("Missing ACK endings: %0d, bus busy endings: %0d, bytes read: %0d.",
			ended_nack, ended_busy, bytes_read);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	function automatic bit field_bad(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	always @(posedge clk) begin : result_check
		result_t want;
		bit      bad;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					errors++;
					$display("%0t: result with no expected item, got done %0b busy %0b",
						$time, done_res, busy_res);
				end else begin
					want = due_results.pop_front();
					bad = 1'b0;
					bad |= field_bad("scl_release", 8'(want.scl_release), 8'(scl_release));
					bad |= field_bad("sda_release", 8'(want.sda_release), 8'(sda_release));
					bad |= field_bad("read_data", want.read_data, read_data);
					bad |= field_bad("read_valid", 8'(want.read_valid), 8'(read_valid));
					bad |= field_bad("read_position", 8'(want.read_position),
						8'(read_position));
					bad |= field_bad("done_res", 8'(want.done_res), 8'(done_res));
					bad |= field_bad("nack_error", 8'(want.nack_error), 8'(nack_error));
					bad |= field_bad("bus_busy_error", 8'(want.bus_busy_error),
						8'(bus_busy_error));
					bad |= field_bad("busy_res", 8'(want.busy_res), 8'(busy_res));
					if (bad) errors++;
				end
				if (done_res === 1'b1) ended++;
				if (nack_error === 1'b1) ended_nack++;
				if (bus_busy_error === 1'b1) ended_busy++;
				if (read_valid === 1'b1) bytes_read++;
			end
			rx_cycle++;
			if (rx_cycle >= HOLD_FROM && rx_cycle < HOLD_FROM + HOLD_LEN) begin
				out_ready <= 1'b0;
			end else if (rx_cycle >= CALM_FROM && rx_cycle < CALM_TO) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= 11);
			end
		end
	end

endmodule
